FILE: src/qpd_pkg.sv
// ----------------------------------------------------------------------------
// qpd_pkg
// Shared types, character codes and the hex digit decode of the
// quoted-printable decoder.
// ----------------------------------------------------------------------------
package qpd_pkg;

	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef enum logic [1:0] {
		PH_PLAIN = 2'd0,
		PH_EQ    = 2'd1,
		PH_HEX1  = 2'd2,
		PH_SOFT  = 2'd3
	} phase_t;

	// one queued item of work: one or two decoded bytes
	typedef struct packed {
		logic       pair;
		logic [7:0] byte0;
		logic [7:0] byte1;
	} cmd_t;

	// queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// bit 4 set when the byte is not a hex digit, else bits 3:0 hold its value
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] r;
		r = 5'h10;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b0, 4'(b - 8'h30)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b0, 4'(b - 8'h37)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b0, 4'(b - 8'h57)};
		end
		return r;
	endfunction

	function automatic logic is_break(input logic [7:0] b);
		return (b == CH_CR) || (b == CH_LF);
	endfunction

endpackage

FILE: src/qpd_front.sv
// ----------------------------------------------------------------------------
// qpd_front
// Accepts encoded bytes, tracks the escape phase and pushes the decoded
// bytes of each item into the queue.
// ----------------------------------------------------------------------------
module qpd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                end_of_text,
	input  qpd_pkg::q_status_t  q_status,
	output logic                push,
	output qpd_pkg::cmd_t       push_cmd
);

	qpd_pkg::phase_t phase_q, phase_d, eff_phase;
	logic [3:0]      nib_q, nib_d;
	logic [4:0]      hv;
	logic            hex_ok;
	logic            brk;
	logic            emit;
	logic            accept;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;
	assign hv       = qpd_pkg::hex_value(in_byte);
	assign hex_ok   = !hv[4];
	assign brk      = qpd_pkg::is_break(in_byte);

	always_comb begin
		phase_d        = phase_q;
		nib_d          = nib_q;
		emit           = 1'b0;
		push_cmd.pair  = 1'b0;
		push_cmd.byte0 = in_byte;
		push_cmd.byte1 = in_byte;
		eff_phase      = phase_q;
		if (in_byte == qpd_pkg::CH_NUL) begin
			phase_d = qpd_pkg::PH_PLAIN;
			nib_d   = 4'h0;
		end else begin
			// a soft break run ends at the first byte that is not CR or LF
			if (phase_q == qpd_pkg::PH_SOFT && !brk) begin
				eff_phase = qpd_pkg::PH_PLAIN;
			end
			unique case (eff_phase)
				qpd_pkg::PH_SOFT: begin
					phase_d = qpd_pkg::PH_SOFT;
				end
				qpd_pkg::PH_PLAIN: begin
					if (in_byte == qpd_pkg::CH_EQ) begin
						phase_d = qpd_pkg::PH_EQ;
					end else begin
						emit    = 1'b1;
						phase_d = qpd_pkg::PH_PLAIN;
					end
				end
				qpd_pkg::PH_EQ: begin
					if (end_of_text) begin
						phase_d = qpd_pkg::PH_PLAIN;
					end else if (hex_ok) begin
						nib_d   = hv[3:0];
						phase_d = qpd_pkg::PH_HEX1;
					end else if (brk) begin
						phase_d = qpd_pkg::PH_SOFT;
					end else begin
						emit           = 1'b1;
						push_cmd.pair  = 1'b1;
						push_cmd.byte0 = qpd_pkg::CH_EQ;
						phase_d        = qpd_pkg::PH_PLAIN;
					end
				end
				qpd_pkg::PH_HEX1: begin
					if (hex_ok) begin
						emit           = 1'b1;
						push_cmd.byte0 = {nib_q, hv[3:0]};
					end else if (brk) begin
						emit = 1'b1;
					end
					phase_d = qpd_pkg::PH_PLAIN;
				end
				default: begin
					phase_d = qpd_pkg::PH_PLAIN;
				end
			endcase
			if (phase_d != qpd_pkg::PH_HEX1) begin
				nib_d = 4'h0;
			end
			if (end_of_text) begin
				phase_d = qpd_pkg::PH_PLAIN;
				nib_d   = 4'h0;
			end
		end
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= qpd_pkg::PH_PLAIN;
			nib_q   <= 4'h0;
		end else if (accept) begin
			phase_q <= phase_d;
			nib_q   <= nib_d;
		end
	end

endmodule

FILE: src/qpd_queue.sv
// ----------------------------------------------------------------------------
// qpd_queue
// Short first-in first-out queue of decoded byte commands between the
// front and the back.
// ----------------------------------------------------------------------------
module qpd_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  qpd_pkg::cmd_t      push_cmd,
	input  logic               pop,
	output qpd_pkg::cmd_t      head_cmd,
	output qpd_pkg::q_status_t q_status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qpd_pkg::cmd_t   mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign q_status.full  = (count_q == CW'(DEPTH));
	assign q_status.empty = (count_q == '0);
	assign do_push        = push && !q_status.full;
	assign do_pop         = pop && !q_status.empty;
	assign head_cmd       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/qpd_back.sv
// ----------------------------------------------------------------------------
// qpd_back
// Pops queued commands and drives the result register, one decoded byte
// per cycle while out_ready allows, marking the last byte of each item.
// ----------------------------------------------------------------------------
module qpd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  qpd_pkg::cmd_t      head_cmd,
	input  qpd_pkg::q_status_t q_status,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               last_of_run
);

	logic       valid_q;
	logic       last_q;
	logic [7:0] byte_q;
	logic       pend_q;
	logic [7:0] pend_byte_q;
	logic       advance;

	assign advance     = !valid_q || out_ready;
	// the second byte of a pair goes out before the queue is read again
	assign pop         = advance && !pend_q && !q_status.empty;
	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign last_of_run = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (advance) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else if (!q_status.empty) begin
				valid_q <= 1'b1;
				pend_q  <= head_cmd.pair;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (pend_q) begin
				byte_q <= pend_byte_q;
				last_q <= 1'b1;
			end else begin
				byte_q      <= head_cmd.byte0;
				last_q      <= !head_cmd.pair;
				pend_byte_q <= head_cmd.byte1;
			end
		end
	end

endmodule

FILE: src/quoted_printable_decoder.sv
// An accepted item is queued, then its byte is registered and shown on out_valid.
// Throughput: one item per cycle while the queue has room; a two-byte item
// holds the output for both bytes, absorbed by the queue as the front accepts.
// The queue depth sets how long the front runs ahead of a stalled output.
// Reset: arst_n clears the escape phase, queue pointers and output valid at once.
// ----------------------------------------------------------------------------
// quoted_printable_decoder
// Quoted-printable decoder: classifying front, command queue, output back.
// ----------------------------------------------------------------------------
module quoted_printable_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	qpd_pkg::q_status_t q_status;
	qpd_pkg::cmd_t      push_cmd;
	qpd_pkg::cmd_t      head_cmd;
	logic               push;
	logic               pop;

	qpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.end_of_text(end_of_text),
		.q_status   (q_status),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	qpd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head_cmd(head_cmd),
		.q_status(q_status)
	);

	qpd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_cmd   (head_cmd),
		.q_status   (q_status),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last_of_run(last_of_run)
	);

endmodule

FILE: src/qpd_checker.sv
// ----------------------------------------------------------------------------
// qpd_checker
// Port-level checks on the decoder output stream, bound to the top level.
// ----------------------------------------------------------------------------
module qpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last_of_run
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(last_of_run))
		else $error("output payload changed while stalled");

	// only the escape char of a pair is ever not the last byte
	a_first_is_eq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> out_byte == qpd_pkg::CH_EQ)
		else $error("non-final byte is not the escape char");

	// second byte of a pair follows right away
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid && last_of_run)
		else $error("second byte of pair not presented next cycle");

endmodule

bind quoted_printable_decoder qpd_checker u_qpd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_byte   (out_byte),
	.last_of_run(last_of_run)
);
